[src/assert_macros.svh]
// Assertion macros shared by the tangent load cell fault check RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define TLC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Property must never hold at a clock edge outside reset.
`define TLC_ASSERT_NEVER(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) !(prop)) else $error(msg);

`endif

[src/tlcfc_pkg.sv]
// Package with types, constants and helper functions for the tangent load cell fault check.
package tlcfc_pkg;

  localparam int unsigned ANGLE_BITS_DEF  = 12;
  localparam int unsigned FORCE_WIDTH_DEF = 20;

  localparam int unsigned LIMIT_W   = 20;
  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned TW_W      = 23;
  localparam int unsigned BR_W      = 21;
  localparam int unsigned NS_W      = 23;
  localparam int unsigned COS_W     = 25;
  localparam int unsigned Q_FRAC    = 30;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_TAN_WEIGHT_LIMIT       = 3'd0,
    REG_LOAD_BEARING_LIMIT     = 3'd1,
    REG_NET_MOMENT_LIMIT       = 3'd2,
    REG_NON_LOAD_BEARING_LIMIT = 3'd3,
    REG_MIRROR_WEIGHT          = 3'd4
  } cfg_reg_e;

  typedef struct packed {
    logic adv;
    logic tail_vld;
  } cos_ctrl_t;

  localparam logic signed [24:0] COS30_Q24 = 25'sd14529495;
  localparam logic [COS_W-1:0]   COS_ONE   = 25'd16777216;

  localparam logic signed [31:0] Q30_ONE  = 32'sd1073741824;
  localparam logic signed [31:0] Q30_HALF = 32'sd536870912;
  localparam logic signed [31:0] PC1      = 32'sd1324675879;
  localparam logic signed [31:0] PC2      = 32'sd272375560;
  localparam logic signed [31:0] PC3      = 32'sd22401992;
  localparam logic signed [31:0] PC4      = 32'sd987048;
  localparam logic signed [31:0] PC5      = 32'sd27060;

  function automatic logic signed [31:0] horner_step(input logic signed [31:0] c,
                                                     input logic signed [31:0] p,
                                                     input logic [Q_FRAC-1:0] u);
    logic signed [62:0] prod;
    logic signed [62:0] rnd;
    prod = 63'(p) * 63'($signed({1'b0, u}));
    rnd  = prod + 63'(Q30_HALF);
    return c - 32'(rnd >>> Q_FRAC);
  endfunction

  function automatic logic [TW_W-1:0] abs_tw(input logic signed [TW_W-1:0] x);
    return x[TW_W-1] ? TW_W'(-x) : TW_W'(x);
  endfunction

  function automatic logic [BR_W-1:0] abs_br(input logic signed [BR_W-1:0] x);
    return x[BR_W-1] ? BR_W'(-x) : BR_W'(x);
  endfunction

endpackage

[src/tangent_load_cell_fault_check.sv]
// Top level of the tangent load cell fault check pipeline.
//
// One transaction on the input channel carries six tangent load cell forces
// and an elevation code; each one produces exactly one transaction on the
// output channel with the tangential weight error, four compensated
// load-bearing forces, the force sum and five fault flags.
// The block takes one transaction per cycle while the receiver is ready.
// Cosine runs through eight stages of a multiplier pipeline, then one stage
// scales it by the mirror weight, one rounds it and two finish the sums and
// compares. All stages advance together: in_ready_o is high when the output
// register is empty or being taken, so a receiver stall holds every stage in
// place and no transaction is lost or repeated.
// Limits and the mirror weight are written through the configuration port,
// which must only be used while no transaction is in flight.
// Reset clears all valid bits and sets every configuration register to zero.
`include "assert_macros.svh"

module tangent_load_cell_fault_check #(
  parameter int unsigned ANGLE_BITS  = tlcfc_pkg::ANGLE_BITS_DEF,
  parameter int unsigned FORCE_WIDTH = tlcfc_pkg::FORCE_WIDTH_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [tlcfc_pkg::CFG_IDX_W-1:0]     cfg_index_i,
  input  logic [tlcfc_pkg::LIMIT_W-1:0]       cfg_data_i,
  input  logic                                in_valid_i,
  output logic                                in_ready_o,
  input  logic signed [FORCE_WIDTH-1:0]       force_one_i,
  input  logic signed [FORCE_WIDTH-1:0]       force_two_i,
  input  logic signed [FORCE_WIDTH-1:0]       force_three_i,
  input  logic signed [FORCE_WIDTH-1:0]       force_four_i,
  input  logic signed [FORCE_WIDTH-1:0]       force_five_i,
  input  logic signed [FORCE_WIDTH-1:0]       force_six_i,
  input  logic [ANGLE_BITS:0]                 elevation_i,
  output logic                                out_valid_o,
  input  logic                                out_ready_i,
  output logic signed [tlcfc_pkg::TW_W-1:0]   tangential_weight_o,
  output logic signed [tlcfc_pkg::BR_W-1:0]   bearing_two_o,
  output logic signed [tlcfc_pkg::BR_W-1:0]   bearing_three_o,
  output logic signed [tlcfc_pkg::BR_W-1:0]   bearing_five_o,
  output logic signed [tlcfc_pkg::BR_W-1:0]   bearing_six_o,
  output logic signed [tlcfc_pkg::NS_W-1:0]   net_sum_o,
  output logic                                weight_fault_o,
  output logic                                bearing_fault_o,
  output logic                                moment_fault_o,
  output logic                                non_bearing_fault_o,
  output logic                                any_fault_o
);
  import tlcfc_pkg::*;

  localparam int unsigned STAGES  = 12;
  localparam int unsigned COS_LAT = 8;
  localparam int unsigned FW      = FORCE_WIDTH;
  localparam int unsigned WIDE    = FW + 8;
  localparam int unsigned PW      = FW + 25;
  localparam int unsigned PTW     = FW + 27;
  localparam int unsigned WC_W    = LIMIT_W + COS_W;
  localparam int unsigned DLY     = 7;

  localparam logic signed [PW-1:0]  RND_P  = {{(PW-24){1'b0}}, 1'b1, 23'd0};
  localparam logic signed [PTW-1:0] RND_T  = {{(PTW-24){1'b0}}, 1'b1, 23'd0};
  localparam logic [WC_W-1:0]       G_HALF = {{(WC_W-24){1'b0}}, 1'b1, 23'd0};
  localparam logic [WC_W-1:0]       Q_HALF = {{(WC_W-26){1'b0}}, 1'b1, 25'd0};
  localparam logic signed [WIDE-1:0] TW_HI = {{(WIDE-TW_W+1){1'b0}}, {(TW_W-1){1'b1}}};
  localparam logic signed [WIDE-1:0] TW_LO = ~TW_HI;
  localparam logic signed [WIDE-1:0] BR_HI = {{(WIDE-BR_W+1){1'b0}}, {(BR_W-1){1'b1}}};
  localparam logic signed [WIDE-1:0] BR_LO = ~BR_HI;

  typedef struct packed {
    logic signed [FW+2:0]  rt;
    logic [3:0][FW:0]      rb;
    logic signed [NS_W-1:0] ns;
    logic                  nf;
  } dly_t;

  function automatic logic [FW-1:0] abs_f(input logic signed [FW-1:0] x);
    return x[FW-1] ? FW'(-x) : FW'(x);
  endfunction

  function automatic logic signed [TW_W-1:0] sat_tw(input logic signed [WIDE-1:0] x);
    if (x > TW_HI) begin
      return TW_HI[TW_W-1:0];
    end else if (x < TW_LO) begin
      return TW_LO[TW_W-1:0];
    end
    return x[TW_W-1:0];
  endfunction

  function automatic logic signed [BR_W-1:0] sat_br(input logic signed [WIDE-1:0] x);
    if (x > BR_HI) begin
      return BR_HI[BR_W-1:0];
    end else if (x < BR_LO) begin
      return BR_LO[BR_W-1:0];
    end
    return x[BR_W-1:0];
  endfunction

  logic [LIMIT_W-1:0] tw_lim_q, lb_lim_q, nm_lim_q, nl_lim_q, weight_q;

  logic              adv;
  logic [STAGES:1]   v_q;
  cos_ctrl_t         cos_ctrl;
  logic [COS_W-1:0]  cos_val;

  logic signed [FW-1:0]   force_q [6];
  logic signed [FW+1:0]   s4_q;
  logic signed [FW+2:0]   nsr_q;
  logic                   nf2_q;
  logic signed [PW-1:0]   pb_q [4];
  logic signed [PTW-1:0]  pt_q;
  logic signed [FW:0]     rb_q [4];
  logic signed [NS_W-1:0] ns3_q;
  logic                   nf3_q;
  dly_t                   dly_d;
  dly_t                   dly_q [DLY];
  logic [WC_W-1:0]        wc_q;
  logic signed [21:0]     g_q;
  logic signed [19:0]     q_q;

  logic signed [WIDE-1:0] tw_w;
  logic signed [WIDE-1:0] bw [4];
  logic signed [TW_W-1:0] tw11_q;
  logic signed [BR_W-1:0] b11_q [4];
  logic signed [NS_W-1:0] ns11_q;
  logic                   nf11_q;

  logic                   bf_d;
  logic signed [TW_W-1:0] tw_q;
  logic signed [BR_W-1:0] br_q [4];
  logic signed [NS_W-1:0] ns_q;
  logic                   wf_q, bf_q, mf_q, nf_q, any_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tw_lim_q <= '0;
      lb_lim_q <= '0;
      nm_lim_q <= '0;
      nl_lim_q <= '0;
      weight_q <= '0;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_TAN_WEIGHT_LIMIT:       tw_lim_q <= cfg_data_i;
        REG_LOAD_BEARING_LIMIT:     lb_lim_q <= cfg_data_i;
        REG_NET_MOMENT_LIMIT:       nm_lim_q <= cfg_data_i;
        REG_NON_LOAD_BEARING_LIMIT: nl_lim_q <= cfg_data_i;
        REG_MIRROR_WEIGHT:          weight_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  assign adv         = !v_q[STAGES] || out_ready_i;
  assign in_ready_o  = adv;
  assign out_valid_o = v_q[STAGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (adv) begin
      v_q <= {v_q[STAGES-1:1], in_valid_i};
    end
  end

  assign cos_ctrl.adv      = adv;
  assign cos_ctrl.tail_vld = v_q[COS_LAT-1];

  tlcfc_cos_pipe #(
    .ANGLE_BITS(ANGLE_BITS)
  ) u_cos (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (cos_ctrl),
    .angle_i (elevation_i),
    .cos_o   (cos_val)
  );

  always_comb begin
    dly_d.rt = (FW+3)'((pt_q + RND_T) >>> 24);
    for (int i = 0; i < 4; i++) begin
      dly_d.rb[i] = rb_q[i];
    end
    dly_d.ns = ns3_q;
    dly_d.nf = nf3_q;
  end

  always_comb begin
    tw_w  = WIDE'($signed(dly_q[DLY-1].rt)) - WIDE'(g_q);
    bw[0] = WIDE'($signed(dly_q[DLY-1].rb[0])) + WIDE'(q_q);
    bw[1] = WIDE'($signed(dly_q[DLY-1].rb[1])) + WIDE'(q_q);
    bw[2] = WIDE'($signed(dly_q[DLY-1].rb[2])) - WIDE'(q_q);
    bw[3] = WIDE'($signed(dly_q[DLY-1].rb[3])) - WIDE'(q_q);
  end

  always_comb begin
    bf_d = 1'b0;
    for (int i = 0; i < 4; i++) begin
      bf_d = bf_d || (abs_br(b11_q[i]) >= BR_W'(lb_lim_q));
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      force_q[0] <= force_one_i;
      force_q[1] <= force_two_i;
      force_q[2] <= force_three_i;
      force_q[3] <= force_four_i;
      force_q[4] <= force_five_i;
      force_q[5] <= force_six_i;

      s4_q  <= (FW+2)'(force_q[4]) + (FW+2)'(force_q[5])
             - (FW+2)'(force_q[1]) - (FW+2)'(force_q[2]);
      nsr_q <= (FW+3)'(force_q[0]) + (FW+3)'(force_q[1]) + (FW+3)'(force_q[2])
             + (FW+3)'(force_q[3]) + (FW+3)'(force_q[4]) + (FW+3)'(force_q[5]);
      nf2_q <= (WIDE'(abs_f(force_q[0])) > WIDE'(nl_lim_q))
            || (WIDE'(abs_f(force_q[3])) > WIDE'(nl_lim_q));
      pb_q[0] <= PW'(force_q[1]) * PW'(COS30_Q24);
      pb_q[1] <= PW'(force_q[2]) * PW'(COS30_Q24);
      pb_q[2] <= PW'(force_q[4]) * PW'(COS30_Q24);
      pb_q[3] <= PW'(force_q[5]) * PW'(COS30_Q24);

      pt_q <= PTW'(s4_q) * PTW'(COS30_Q24);
      for (int i = 0; i < 4; i++) begin
        rb_q[i] <= (FW+1)'((pb_q[i] + RND_P) >>> 24);
      end
      ns3_q <= sat_tw(WIDE'(nsr_q));
      nf3_q <= nf2_q;

      dly_q[0] <= dly_d;
      for (int k = 1; k < DLY; k++) begin
        dly_q[k] <= dly_q[k-1];
      end

      wc_q <= WC_W'(weight_q) * WC_W'(cos_val);
      g_q  <= 22'((wc_q + G_HALF) >> 24);
      q_q  <= 20'((wc_q + Q_HALF) >> 26);

      tw11_q <= sat_tw(tw_w);
      for (int i = 0; i < 4; i++) begin
        b11_q[i] <= sat_br(bw[i]);
      end
      ns11_q <= dly_q[DLY-1].ns;
      nf11_q <= dly_q[DLY-1].nf;

      tw_q <= tw11_q;
      for (int i = 0; i < 4; i++) begin
        br_q[i] <= b11_q[i];
      end
      ns_q  <= ns11_q;
      wf_q  <= abs_tw(tw11_q) >= TW_W'(tw_lim_q);
      bf_q  <= bf_d;
      mf_q  <= abs_tw(ns11_q) > TW_W'(nm_lim_q);
      nf_q  <= nf11_q;
      any_q <= (abs_tw(tw11_q) >= TW_W'(tw_lim_q)) || bf_d
            || (abs_tw(ns11_q) > TW_W'(nm_lim_q)) || nf11_q;
    end
  end

  assign tangential_weight_o = tw_q;
  assign bearing_two_o       = br_q[0];
  assign bearing_three_o     = br_q[1];
  assign bearing_five_o      = br_q[2];
  assign bearing_six_o       = br_q[3];
  assign net_sum_o           = ns_q;
  assign weight_fault_o      = wf_q;
  assign bearing_fault_o     = bf_q;
  assign moment_fault_o      = mf_q;
  assign non_bearing_fault_o = nf_q;
  assign any_fault_o         = any_q;

  `TLC_ASSERT(a_stall_holds_stages, !in_ready_o |=> $stable(v_q), "Pipeline moved during a stall.")
  `TLC_ASSERT(a_zero_weight_limit, adv && v_q[STAGES-1] && tw_lim_q == '0 |=> weight_fault_o && any_fault_o, "Weight fault missing with a zero limit.")
  `TLC_ASSERT(a_moment_needs_sum, out_valid_o && moment_fault_o |-> net_sum_o != '0, "Moment fault with a zero force sum.")

endmodule

[src/tlcfc_cos_pipe.sv]
// Pipelined quarter-wave cosine in Q24 from an elevation code, by Horner evaluation.
`include "assert_macros.svh"

module tlcfc_cos_pipe #(
  parameter int unsigned ANGLE_BITS = tlcfc_pkg::ANGLE_BITS_DEF
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  tlcfc_pkg::cos_ctrl_t       ctrl_i,
  input  logic [ANGLE_BITS:0]        angle_i,
  output logic [tlcfc_pkg::COS_W-1:0] cos_o
);
  import tlcfc_pkg::*;

  localparam int unsigned SHIFT = Q_FRAC - ANGLE_BITS;

  logic [Q_FRAC-1:0]   t_q;
  logic [2*Q_FRAC-1:0] sq;
  logic [Q_FRAC-1:0]   u_d;
  logic [Q_FRAC-1:0]   u_q [2:6];
  logic                z_q [1:7];
  logic signed [31:0]  p_q [3:7];
  logic signed [31:0]  p_rnd;
  logic [COS_W-1:0]    cos_d;
  logic [COS_W-1:0]    cos_q;

  assign sq    = (2*Q_FRAC)'(t_q) * (2*Q_FRAC)'(t_q);
  assign u_d   = Q_FRAC'((sq + (2*Q_FRAC)'(Q30_HALF)) >> Q_FRAC);
  assign p_rnd = p_q[7] + 32'sd32;

  always_comb begin
    if (z_q[7] || p_q[7][31]) begin
      cos_d = '0;
    end else begin
      cos_d = COS_W'(p_rnd >>> 6);
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.adv) begin
      t_q    <= Q_FRAC'(angle_i[ANGLE_BITS-1:0]) << SHIFT;
      z_q[1] <= angle_i[ANGLE_BITS];
      for (int k = 2; k <= 7; k++) begin
        z_q[k] <= z_q[k-1];
      end
      u_q[2] <= u_d;
      for (int k = 3; k <= 6; k++) begin
        u_q[k] <= u_q[k-1];
      end
      p_q[3] <= horner_step(PC4, PC5, u_q[2]);
      p_q[4] <= horner_step(PC3, p_q[3], u_q[3]);
      p_q[5] <= horner_step(PC2, p_q[4], u_q[4]);
      p_q[6] <= horner_step(PC1, p_q[5], u_q[5]);
      p_q[7] <= horner_step(Q30_ONE, p_q[6], u_q[6]);
      cos_q  <= cos_d;
    end
  end

  assign cos_o = cos_q;

  `TLC_ASSERT(a_cos_zero_at_limit, ctrl_i.adv && ctrl_i.tail_vld && z_q[7] |=> cos_q == '0, "Cosine not zero at ninety degrees or beyond.")
  `TLC_ASSERT_NEVER(a_cos_above_one, $past(ctrl_i.adv && ctrl_i.tail_vld) && cos_q > COS_ONE, "Cosine above one.")

endmodule
